### hw/rtl/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg: shared types and constants for the marching squares cell segmenter
// Field widths, edge codes, the case table and the divider request type.
// ----------------------------------------------------------------------------
`default_nettype none

package msq_pkg;

   localparam int SAMPLE_W     = 24;
   localparam int MAG_W        = SAMPLE_W + 1;
   localparam int EDGE_W       = 21;
   localparam int BASE_W       = EDGE_W - 1;
   localparam int FRAC_W       = 16;
   localparam int COLS_REG_W   = 11;
   localparam int DEF_MAX_COLS = 1024;
   localparam int DEF_MAX_ROWS = 1024;
   localparam int LANES        = 4;

   typedef logic [1:0] edge_type;
   localparam edge_type EDGE_B = 2'd0;
   localparam edge_type EDGE_T = 2'd1;
   localparam edge_type EDGE_L = 2'd2;
   localparam edge_type EDGE_R = 2'd3;

   typedef struct packed {
      logic [1:0] count;
      edge_type   a0;
      edge_type   b0;
      edge_type   a1;
      edge_type   b1;
   } seg_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] num;
      logic [MAG_W-1:0] den;
   } div_req_type;

   function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] v);
      logic [MAG_W-1:0] e;
      begin
         e = {v[SAMPLE_W-1], v};
         return v[SAMPLE_W-1] ? (~e + 1'b1) : e;
      end
   endfunction

   // Segments are directed so that filled space lies on the left.
   function automatic seg_type seg_lookup(input logic [3:0] mask, input logic center);
      seg_type s;
      begin
         s = '{2'd0, EDGE_B, EDGE_B, EDGE_B, EDGE_B};
         case (mask)
            4'd1:  s = '{2'd1, EDGE_B, EDGE_L, EDGE_B, EDGE_B};
            4'd2:  s = '{2'd1, EDGE_R, EDGE_B, EDGE_B, EDGE_B};
            4'd3:  s = '{2'd1, EDGE_R, EDGE_L, EDGE_B, EDGE_B};
            4'd4:  s = '{2'd1, EDGE_T, EDGE_R, EDGE_B, EDGE_B};
            4'd5:  s = center ? '{2'd2, EDGE_B, EDGE_R, EDGE_T, EDGE_L}
                              : '{2'd2, EDGE_B, EDGE_L, EDGE_T, EDGE_R};
            4'd6:  s = '{2'd1, EDGE_T, EDGE_B, EDGE_B, EDGE_B};
            4'd7:  s = '{2'd1, EDGE_T, EDGE_L, EDGE_B, EDGE_B};
            4'd8:  s = '{2'd1, EDGE_L, EDGE_T, EDGE_B, EDGE_B};
            4'd9:  s = '{2'd1, EDGE_B, EDGE_T, EDGE_B, EDGE_B};
            4'd10: s = center ? '{2'd2, EDGE_L, EDGE_B, EDGE_R, EDGE_T}
                              : '{2'd2, EDGE_R, EDGE_B, EDGE_L, EDGE_T};
            4'd11: s = '{2'd1, EDGE_R, EDGE_T, EDGE_B, EDGE_B};
            4'd12: s = '{2'd1, EDGE_L, EDGE_R, EDGE_B, EDGE_B};
            4'd13: s = '{2'd1, EDGE_B, EDGE_R, EDGE_B, EDGE_B};
            4'd14: s = '{2'd1, EDGE_L, EDGE_B, EDGE_B, EDGE_B};
            default: s = '{2'd0, EDGE_B, EDGE_B, EDGE_B, EDGE_B};
         endcase
         return s;
      end
   endfunction

endpackage

`default_nettype wire

### hw/rtl/marching_squares_cell_segments.sv
// ----------------------------------------------------------------------------
// marching_squares_cell_segments: streaming marching squares segmenter
// Keeps the previous grid row in a memory and emits the directed segments
// of each completed cell with their interpolated edge crossings.
//
//   Port group   Direction   Handshake           Moves
//   req_*        in          valid / stall       one grid sample request
//   rsp_*        out         valid / stall       one segment
//   p*           in / out    APB, pready high    cols_in_use register
//
// A sample passes the read and write-back states and returns to idle when
// it completes no cell or the cell has no segment; otherwise it waits for
// the 16 step crossing dividers and then emits its segments in turn. No
// divider has to iterate when every edge has two zero corners or a
// saturated fraction. Reset is synchronous and clears the counters; the
// row memory is not cleared. A stalled segment holds and the request side
// stalls until the last segment of the sample is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module marching_squares_cell_segments #(
   parameter int MAX_COLS = msq_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = msq_pkg::DEF_MAX_ROWS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_frame_start,
   input  wire logic signed [msq_pkg::SAMPLE_W-1:0] req_sample_value,
   input  wire logic                              req_center_inside,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [msq_pkg::EDGE_W-1:0]             rsp_start_edge,
   output logic [msq_pkg::EDGE_W-1:0]             rsp_end_edge,
   output logic [msq_pkg::FRAC_W-1:0]             rsp_start_frac,
   output logic [msq_pkg::FRAC_W-1:0]             rsp_end_frac,
   output logic                                   rsp_last_of_cell,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [2:0]                        paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import msq_pkg::*;

   localparam int IDX_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int CNT_W = $clog2(MAX_COLS + 1);
   localparam int CMP_W = (CNT_W > COLS_REG_W) ? CNT_W : COLS_REG_W;
   localparam int MUL_A = ROW_W + CMP_W + 1;
   localparam int MUL_W = (MUL_A > BASE_W) ? MUL_A : BASE_W;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_WEND = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [COLS_REG_W-1:0]  cols_reg_ff;
   logic [IDX_W-1:0]       col_ff;
   logic [ROW_W-1:0]       row_ff;
   logic [SAMPLE_W-1:0]    left_ff;
   logic [SAMPLE_W-1:0]    cur_ff;
   logic                   center_ff;
   logic [IDX_W-1:0]       wcol_ff;
   logic [ROW_W-1:0]       wrow_ff;
   logic                   end_row_ff;
   logic                   act_ff;
   seg_type                seg_ff;
   logic                   seg_idx_ff;
   logic [BASE_W-1:0]      base_ff;
   logic [SAMPLE_W-1:0]    rd0_ff, rd1_ff;
   logic [SAMPLE_W-1:0]    row_mem [MAX_COLS];

   logic [CMP_W-1:0]       cols_ext, cols_eff;
   logic                   accept, emit_take;
   logic [IDX_W-1:0]       sel_col, rd0_addr;
   logic [ROW_W-1:0]       sel_row;
   logic                   end_row;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [SAMPLE_W-1:0]    mem_wdata;
   logic [3:0]             mask;
   seg_type                seg_now;
   logic [MUL_W-1:0]       base_full;
   logic [MAG_W-1:0]       m0, m1, m2, m3;
   div_req_type            div_req [LANES];
   logic [LANES-1:0]       div_busy;
   logic [FRAC_W-1:0]      div_quot [LANES];
   edge_type               code_start, code_end;

   function automatic logic [EDGE_W-1:0] edge_id(input edge_type code,
                                                 input logic [BASE_W-1:0] base,
                                                 input logic [BASE_W-1:0] cols);
      logic [EDGE_W-1:0] id;
      begin
         unique case (code)
            EDGE_B: id = {base, 1'b0};
            EDGE_T: id = {base + cols, 1'b0};
            EDGE_L: id = {base, 1'b1};
            EDGE_R: id = {base + 1'b1, 1'b1};
         endcase
         return id;
      end
   endfunction

   // Configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_reg_ff <= COLS_REG_W'(1024);
      end else if (psel && penable && pwrite && !paddr[2]) begin
         cols_reg_ff <= pwdata[COLS_REG_W-1:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : 32'(cols_reg_ff);

   always_comb begin
      cols_ext = CMP_W'(cols_reg_ff);
      if (cols_ext < CMP_W'(2)) begin
         cols_eff = CMP_W'(2);
      end else if (cols_ext > CMP_W'(MAX_COLS)) begin
         cols_eff = CMP_W'(MAX_COLS);
      end else begin
         cols_eff = cols_ext;
      end
   end

   // Request side.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign emit_take = (state_ff == S_EMIT) && !rsp_stall;

   always_comb begin
      sel_col  = req_frame_start ? '0 : col_ff;
      sel_row  = req_frame_start ? '0 : row_ff;
      rd0_addr = sel_col - 1'b1;
      end_row  = ((CMP_W'(sel_col) + 1'b1) >= cols_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (end_row) begin
            col_ff <= '0;
            row_ff <= (sel_row == ROW_W'(MAX_ROWS - 1)) ? '0 : sel_row + 1'b1;
         end else begin
            col_ff <= sel_col + 1'b1;
            row_ff <= sel_row;
         end
      end
   end

   // Row memory: two registered reads, one write.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = wcol_ff - 1'b1;
      mem_wdata = left_ff;
      if (state_ff == S_READ) begin
         mem_we = (wcol_ff != '0);
      end else if (state_ff == S_WEND) begin
         mem_we    = end_row_ff;
         mem_waddr = wcol_ff;
         mem_wdata = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd0_ff <= row_mem[rd0_addr];
         rd1_ff <= row_mem[sel_col];
      end
   end

   // Cell evaluation.
   always_comb begin
      mask      = {left_ff[SAMPLE_W-1], cur_ff[SAMPLE_W-1],
                   rd1_ff[SAMPLE_W-1], rd0_ff[SAMPLE_W-1]};
      seg_now   = seg_lookup(mask, center_ff);
      base_full = MUL_W'(wrow_ff - 1'b1) * MUL_W'(cols_eff) + MUL_W'(wcol_ff - 1'b1);
      m0        = sample_mag(rd0_ff);
      m1        = sample_mag(rd1_ff);
      m2        = sample_mag(cur_ff);
      m3        = sample_mag(left_ff);
      div_req[EDGE_B] = '{state_ff == S_READ, m0, m0 + m1};
      div_req[EDGE_T] = '{state_ff == S_READ, m3, m3 + m2};
      div_req[EDGE_L] = '{state_ff == S_READ, m0, m0 + m3};
      div_req[EDGE_R] = '{state_ff == S_READ, m1, m1 + m2};
   end

   for (genvar g = 0; g < LANES; g++) begin : g_div
      msq_frac_div u_div (
         .clock (clock),
         .reset (reset),
         .req   (div_req[g]),
         .busy  (div_busy[g]),
         .quot  (div_quot[g])
      );
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff     <= req_sample_value;
         center_ff  <= req_center_inside;
         wcol_ff    <= sel_col;
         wrow_ff    <= sel_row;
         end_row_ff <= end_row;
      end
      if (state_ff == S_READ) begin
         seg_ff  <= seg_now;
         base_ff <= base_full[BASE_W-1:0];
         act_ff  <= (wcol_ff != '0) && (wrow_ff != '0) && (seg_now.count != 2'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (state_ff == S_WEND) begin
         left_ff <= cur_ff;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_READ;
         S_READ: state_in = S_WEND;
         S_WEND: state_in = act_ff ? S_DIV : S_IDLE;
         S_DIV:  if (div_busy == '0) state_in = S_EMIT;
         S_EMIT: begin
            if (emit_take && (seg_idx_ff || (seg_ff.count != 2'd2))) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         seg_idx_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DIV) begin
            seg_idx_ff <= 1'b0;
         end else if (emit_take) begin
            seg_idx_ff <= 1'b1;
         end
      end
   end

   // Result side.
   always_comb begin
      code_start       = seg_idx_ff ? seg_ff.a1 : seg_ff.a0;
      code_end         = seg_idx_ff ? seg_ff.b1 : seg_ff.b0;
      rsp_valid        = (state_ff == S_EMIT);
      rsp_start_edge   = edge_id(code_start, base_ff, BASE_W'(cols_eff));
      rsp_end_edge     = edge_id(code_end, base_ff, BASE_W'(cols_eff));
      rsp_start_frac   = div_quot[code_start];
      rsp_end_frac     = div_quot[code_end];
      rsp_last_of_cell = seg_idx_ff || (seg_ff.count != 2'd2);
   end

endmodule

`default_nettype wire

### hw/rtl/msq_frac_div.sv
// ----------------------------------------------------------------------------
// msq_frac_div: crossing fraction divider
// Restoring division of num/den into an unsigned Q0.16 fraction, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_frac_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire msq_pkg::div_req_type        req,
   output logic                             busy,
   output logic [msq_pkg::FRAC_W-1:0]       quot
);
   import msq_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W + 1);

   logic                busy_ff;
   logic [MAG_W-1:0]    rem_ff;
   logic [MAG_W-1:0]    den_ff;
   logic [FRAC_W-1:0]   quot_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [MAG_W:0]      rem2;
   logic [MAG_W:0]      diff;
   logic                fits;

   always_comb begin
      rem2 = {rem_ff, 1'b0};
      diff = rem2 - {1'b0, den_ff};
      fits = (rem2 >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (req.start) begin
         busy_ff <= (req.den != '0) && (req.num < req.den);
      end else if (busy_ff && (cnt_ff == CNT_W'(1))) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= req.num;
         den_ff <= req.den;
         cnt_ff <= CNT_W'(FRAC_W);
         if (req.den == '0) begin
            quot_ff <= '0;
         end else if (req.num >= req.den) begin
            quot_ff <= '1;
         end else begin
            quot_ff <= '0;
         end
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
         quot_ff <= {quot_ff[FRAC_W-2:0], fits};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

### hw/rtl/msq_checker.sv
// ----------------------------------------------------------------------------
// msq_checker: port level checks for the marching squares segmenter
// Watches the request and segment channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module msq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [msq_pkg::EDGE_W-1:0]    rsp_start_edge,
   input wire logic [msq_pkg::EDGE_W-1:0]    rsp_end_edge,
   input wire logic [msq_pkg::FRAC_W-1:0]    rsp_start_frac,
   input wire logic [msq_pkg::FRAC_W-1:0]    rsp_end_frac,
   input wire logic                          rsp_last_of_cell
);
   import msq_pkg::*;

   // A stalled segment keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_start_edge)
         && $stable(rsp_end_edge) && $stable(rsp_start_frac)
         && $stable(rsp_end_frac) && $stable(rsp_last_of_cell))
      else $error("stalled segment changed");

   // No segment shows in the cycle right after a request is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("segment too early after request");

   // The second segment of a cell follows the first without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_cell |=> rsp_valid)
      else $error("second segment missing");

   // No request is taken while a segment is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while segment pending");

endmodule

bind marching_squares_cell_segments msq_checker u_msq_checker (.*);

`default_nettype wire

### test/marching_squares_cell_segments_test.sv
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_test: self-checking bench for the segmenter
// Streams grid samples at several row widths through the request channel.
// Every accepted request is run through an in-bench marching squares
// predictor, and each segment that comes back is compared field by field with
// the oldest predicted segment. Both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module marching_squares_cell_segments_test;
   import msq_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int ROW_SLOTS = DEF_MAX_COLS;
   localparam logic [2:0] COLS_ADDR = 3'd0;

   typedef struct {
      logic [EDGE_W-1:0] start_edge;
      logic [EDGE_W-1:0] end_edge;
      logic [FRAC_W-1:0] start_frac;
      logic [FRAC_W-1:0] end_frac;
      logic last_of_cell;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_frame_start = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample_value = '0;
   logic req_center_inside = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [EDGE_W-1:0] rsp_start_edge;
   logic [EDGE_W-1:0] rsp_end_edge;
   logic [FRAC_W-1:0] rsp_start_frac;
   logic [FRAC_W-1:0] rsp_end_frac;
   logic rsp_last_of_cell;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   segment_type pending_segments[$];
   logic [SAMPLE_W-1:0] row_mem [ROW_SLOTS];
   logic [SAMPLE_W-1:0] left_val = '0;
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;
   logic [COLS_REG_W-1:0] cols_setting = 11'd1024;
   int error_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit quiet = 1'b0;

   marching_squares_cell_segments uut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("marching_squares_cell_segments_test: errors");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (quiet || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   function automatic logic [FRAC_W-1:0] crossing(logic [SAMPLE_W-1:0] va,
                                                  logic [SAMPLE_W-1:0] vb);
      longint sa, sb;
      longint unsigned num, den, q;
      sa = longint'($signed(va));
      sb = longint'($signed(vb));
      num = (sa < 0) ? -sa : sa;
      den = num + ((sb < 0) ? -sb : sb);
      if (den == 0) return '0;
      q = (num << FRAC_W) / den;
      if (q > 65535) q = 65535;
      return q[FRAC_W-1:0];
   endfunction

   // Directed segments for each corner mask; filled space lies on the left.
   function automatic int cell_paths(logic [3:0] mask, logic center,
                                     output edge_type from_e[2],
                                     output edge_type to_e[2]);
      from_e[1] = EDGE_B;
      to_e[1] = EDGE_B;
      case (mask)
         4'd1, 4'd5: begin from_e[0] = EDGE_B; to_e[0] = EDGE_L; end
         4'd2, 4'd10: begin from_e[0] = EDGE_R; to_e[0] = EDGE_B; end
         4'd3: begin from_e[0] = EDGE_R; to_e[0] = EDGE_L; end
         4'd4: begin from_e[0] = EDGE_T; to_e[0] = EDGE_R; end
         4'd6: begin from_e[0] = EDGE_T; to_e[0] = EDGE_B; end
         4'd7: begin from_e[0] = EDGE_T; to_e[0] = EDGE_L; end
         4'd8: begin from_e[0] = EDGE_L; to_e[0] = EDGE_T; end
         4'd9: begin from_e[0] = EDGE_B; to_e[0] = EDGE_T; end
         4'd11: begin from_e[0] = EDGE_R; to_e[0] = EDGE_T; end
         4'd12: begin from_e[0] = EDGE_L; to_e[0] = EDGE_R; end
         4'd13: begin from_e[0] = EDGE_B; to_e[0] = EDGE_R; end
         4'd14: begin from_e[0] = EDGE_L; to_e[0] = EDGE_B; end
         default: return 0;
      endcase
      if (mask == 4'd5) begin
         from_e[1] = EDGE_T;
         to_e[1] = center ? EDGE_L : EDGE_R;
         if (center) to_e[0] = EDGE_R;
         return 2;
      end
      if (mask == 4'd10) begin
         from_e[1] = center ? EDGE_R : EDGE_L;
         to_e[1] = EDGE_T;
         if (center) from_e[0] = EDGE_L;
         return 2;
      end
      return 1;
   endfunction

   task automatic predict_segments(logic fs, logic [SAMPLE_W-1:0] cur, logic center);
      int unsigned width, c;
      longint unsigned i, j;
      logic [SAMPLE_W-1:0] v[4];
      logic [3:0] mask;
      logic [EDGE_W-1:0] ids[4];
      logic [FRAC_W-1:0] fr[4];
      edge_type from_e[2], to_e[2];
      int n;
      segment_type s;
      width = cols_setting < 2 ? 2 : (cols_setting > ROW_SLOTS ? ROW_SLOTS : cols_setting);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      if (c >= 1) begin
         v[0] = row_mem[c-1];
         v[1] = row_mem[c];
         v[2] = cur;
         v[3] = left_val;
         row_mem[c-1] = left_val;
         if (row_pos >= 1) begin
            i = c - 1;
            j = row_pos - 1;
            for (int k = 0; k < 4; k++) mask[k] = v[k][SAMPLE_W-1];
            ids[EDGE_B] = EDGE_W'((j * width + i) * 2);
            ids[EDGE_T] = EDGE_W'(((j + 1) * width + i) * 2);
            ids[EDGE_L] = EDGE_W'((j * width + i) * 2 + 1);
            ids[EDGE_R] = EDGE_W'((j * width + i + 1) * 2 + 1);
            fr[EDGE_B] = crossing(v[0], v[1]);
            fr[EDGE_T] = crossing(v[3], v[2]);
            fr[EDGE_L] = crossing(v[0], v[3]);
            fr[EDGE_R] = crossing(v[1], v[2]);
            n = cell_paths(mask, center, from_e, to_e);
            for (int k = 0; k < n; k++) begin
               s.start_edge = ids[from_e[k]];
               s.end_edge = ids[to_e[k]];
               s.start_frac = fr[from_e[k]];
               s.end_frac = fr[to_e[k]];
               s.last_of_cell = (k == n - 1);
               pending_segments = {pending_segments, s};
            end
         end
      end
      if (c + 1 >= width) begin
         row_mem[c] = cur;
         col_pos = 0;
         row_pos = (row_pos + 1) % DEF_MAX_ROWS;
      end else begin
         col_pos = c + 1;
      end
      left_val = cur;
   endtask

   always @(posedge clock) begin
      segment_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_segments.size() == 0) begin
            $error("segment with none expected: start_edge %0d", rsp_start_edge);
            error_count++;
         end else begin
            e = pending_segments.pop_front();
            if (rsp_start_edge !== e.start_edge) begin
               $error("start_edge expected %0d actual %0d", e.start_edge, rsp_start_edge);
               error_count++;
            end
            if (rsp_end_edge !== e.end_edge) begin
               $error("end_edge expected %0d actual %0d", e.end_edge, rsp_end_edge);
               error_count++;
            end
            if (rsp_start_frac !== e.start_frac) begin
               $error("start_frac expected %0d actual %0d", e.start_frac, rsp_start_frac);
               error_count++;
            end
            if (rsp_end_frac !== e.end_frac) begin
               $error("end_frac expected %0d actual %0d", e.end_frac, rsp_end_frac);
               error_count++;
            end
            if (rsp_last_of_cell !== e.last_of_cell) begin
               $error("last_of_cell expected %0b actual %0b", e.last_of_cell,
                      rsp_last_of_cell);
               error_count++;
            end
         end
      end
   end

   task automatic send_sample(logic fs, logic [SAMPLE_W-1:0] value, logic center);
      int gap;
      req_valid <= 1'b1;
      req_frame_start <= fs;
      req_sample_value <= value;
      req_center_inside <= center;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      predict_segments(fs, value, center);
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_cols(logic [COLS_REG_W-1:0] value);
      req_valid <= 1'b0;
      wait (pending_segments.size() == 0);
      repeat (40) @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= COLS_ADDR;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      cols_setting = value;
      @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0, 1, 2: return SAMPLE_W'($signed($urandom_range(0, 600)) - 300);
         3: begin
            case ($urandom_range(0, 4))
               0: return 24'h800000;
               1: return 24'h7fffff;
               2: return 24'h000000;
               3: return 24'hffffff;
               default: return 24'h000001;
            endcase
         end
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   task automatic run_grid(int count, int fs_per_mille);
      logic fs;
      for (int n = 0; n < count; n++) begin
         fs = (n == 0) || ($urandom_range(0, 999) < fs_per_mille);
         send_sample(fs, random_sample(), $urandom_range(0, 1));
      end
   endtask

   task automatic test_directed_cells();
      logic [SAMPLE_W-1:0] rows[24] = '{
         24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 24'hffffff, 24'h000001,
         24'h000001, 24'hffffff, 24'hffffff, 24'h000001, 24'h000000, 24'h000000,
         24'hfffffb, 24'hfffff9, 24'h800000, 24'hffffff, 24'h000000, 24'h7fffff,
         24'h000000, 24'h800000, 24'hfffed4, 24'h00012c, 24'h7fffff, 24'h000000};
      write_cols(11'd2);
      quiet = 1'b1;
      for (int k = 0; k < 24; k++) send_sample(k == 0, rows[k], 1'(((k / 2) / 2) % 2));
      quiet = 1'b0;
   endtask

   task automatic test_reset_width();
      logic [31:0] value;
      psel <= 1'b1;
      pwrite <= 1'b0;
      paddr <= COLS_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      value = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (value !== 32'd1024) begin
         $error("cols_in_use expected %0d actual %0d", 1024, value);
         error_count++;
      end
      @(posedge clock);
      run_grid(40, 0);
   endtask

   task automatic test_widest_setting();
      write_cols(11'd2047);
      run_grid(1060, 0);
   endtask

   task automatic test_small_grids();
      logic [COLS_REG_W-1:0] widths[4] = '{11'd3, 11'd5, 11'd17, 11'd1};
      foreach (widths[w]) begin
         write_cols(widths[w]);
         quiet = (w == 2);
         run_grid(40, 20);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_width();
      test_directed_cells();
      test_small_grids();
      test_widest_setting();
      req_valid <= 1'b0;
      wait (pending_segments.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("marching_squares_cell_segments_test: clean");
      end else begin
         $display("marching_squares_cell_segments_test: errors");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/msq_pkg.sv
hw/rtl/msq_frac_div.sv
hw/rtl/marching_squares_cell_segments.sv
hw/rtl/msq_checker.sv
test/marching_squares_cell_segments_test.sv
